@@ rtl/bollinger_band_calculator_assert.svh @@
// Assertion helpers for the band calculator checkers.
`ifndef BOLLINGER_BAND_CALCULATOR_ASSERT_SVH
`define BOLLINGER_BAND_CALCULATOR_ASSERT_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define BBC_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("bbc check failed");

// Next-cycle implication, sampled on clk, off during reset.
`define BBC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("bbc check failed");

`endif

@@ rtl/bbc_pkg.sv @@
`timescale 1ns / 1ps

package bbc_pkg;

  localparam int MAX_WINDOW = 256;
  localparam int PRICE_BITS = 24;
  localparam int WIN_AW     = $clog2(MAX_WINDOW);
  localparam int LEN_W      = 9;
  localparam int MULT_W     = 12;
  localparam int SUM_W      = 32;
  localparam int SQ_W       = 56;
  localparam int CNT_W      = 7;

  localparam logic [CNT_W-1:0] DIV_VAR_STEPS  = CNT_W'(64);
  localparam logic [CNT_W-1:0] DIV_MEAN_STEPS = CNT_W'(32);
  localparam logic [CNT_W-1:0] SQRT_STEPS     = CNT_W'(24);

  localparam logic REG_WINDOW_LENGTH   = 1'b0;
  localparam logic REG_BAND_MULTIPLIER = 1'b1;

  localparam logic [LEN_W-1:0]  WINDOW_LENGTH_RST   = LEN_W'(20);
  localparam logic [MULT_W-1:0] BAND_MULTIPLIER_RST = MULT_W'(512);

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_UPD,
    ST_SQ_ADD,
    ST_SQ_SUB,
    ST_LQ_LO,
    ST_LQ_HI,
    ST_SS,
    ST_NUM,
    ST_LL,
    ST_DIV_VAR,
    ST_MEAN_INIT,
    ST_DIV_MEAN,
    ST_SQRT_INIT,
    ST_SQRT,
    ST_OFF,
    ST_RES
  } state_t;

endpackage

@@ rtl/bbc_ram.sv @@
`timescale 1ns / 1ps

module bbc_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

@@ rtl/bollinger_band_calculator.sv @@
`timescale 1ns / 1ps
// Bollinger band calculator.
// Input request: sample_price with in_valid/in_ready; one closing price per request.
// Output request: ready_res, upper_band, lower_band with out_valid/out_ready;
// exactly one result per accepted price.
// Registers via APB: window_length at 0x0, band_multiplier at 0x4 (Q4.8).
// Writing window_length empties the window (fill count and running sums).
// A price is taken only in idle; in_ready stays low while it is processed.
// While the window fills the result is all zeros.
// With a full window each price goes through a 64-step restoring divide for
// the variance, a 32-step divide for the mean and a 24-step square root, all
// on one shared compare/subtract unit, and uses one shared 32x32 multiplier
// for the squares and products.
// Results sit in an output register; a stalled receiver holds it and the next
// price may still be taken, but its result waits until the register is free.
// Synchronous reset sets window_length 20, band_multiplier 512 (2.0) and an
// empty window. The price ring needs no clearing pass.
module bollinger_band_calculator import bbc_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic [PRICE_BITS-1:0]   sample_price,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic                    ready_res,
  output logic [27:0]             upper_band,
  output logic signed [28:0]      lower_band,
  input  logic                    psel,
  input  logic                    penable,
  input  logic                    pwrite,
  input  logic [2:0]              paddr,
  input  logic [31:0]             pwdata,
  output logic [31:0]             prdata,
  output logic                    pready
);

  state_t state, state_next;

  logic [LEN_W-1:0]      window_length;
  logic [MULT_W-1:0]     band_multiplier;
  logic [LEN_W-1:0]      fill_count;
  logic [WIN_AW-1:0]     write_position;
  logic [SUM_W-1:0]      window_sum;
  logic [SQ_W-1:0]       window_square_sum;
  logic [PRICE_BITS-1:0] price;
  logic [PRICE_BITS-1:0] old_price;
  logic                  was_full;
  logic                  band_ok;
  logic [63:0]           prod;
  logic [63:0]           acc;
  logic [63:0]           dvd;
  logic [24:0]           rem;
  logic [23:0]           root;
  logic [16:0]           divisor;
  logic [23:0]           mean;
  logic [CNT_W-1:0]      cnt;

  logic [LEN_W-1:0]      len;
  logic                  cfg_we;
  logic                  in_acc;
  logic                  can_load;
  logic                  full_now;

  logic                  ram_we;
  logic [WIN_AW-1:0]     ram_addr;
  logic [PRICE_BITS-1:0] ram_rdata;

  logic [31:0]           mul_a;
  logic [31:0]           mul_b;
  logic [63:0]           mul_p;

  logic [26:0]           sub_a;
  logic [26:0]           sub_b;
  logic [27:0]           sub_diff;
  logic                  sub_ok;

  logic [17:0]           div_shift;
  logic [26:0]           sqrt_shift;
  logic [27:0]           offset;

  assign pready   = 1'b1;
  assign cfg_we   = psel & penable & pwrite;
  assign in_acc   = in_valid & in_ready;
  assign can_load = ~out_valid | out_ready;

  always_comb begin
    if (window_length == '0) begin
      len = LEN_W'(1);
    end else if (window_length > LEN_W'(MAX_WINDOW)) begin
      len = LEN_W'(MAX_WINDOW);
    end else begin
      len = window_length;
    end
  end

  assign full_now = fill_count >= len;

  always_comb begin
    case (paddr[2])
      REG_WINDOW_LENGTH:   prdata = {{(32-LEN_W){1'b0}}, window_length};
      REG_BAND_MULTIPLIER: prdata = {{(32-MULT_W){1'b0}}, band_multiplier};
      default:             prdata = '0;
    endcase
  end

  bbc_ram #(
    .WIDTH (PRICE_BITS),
    .DEPTH (MAX_WINDOW)
  ) u_ring (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (price),
    .rdata (ram_rdata)
  );

  // shared multiplier and compare/subtract unit
  assign mul_p      = mul_a * mul_b;
  assign sub_diff   = {1'b0, sub_a} - {1'b0, sub_b};
  assign sub_ok     = ~sub_diff[27];
  assign div_shift  = {rem[16:0], dvd[63]};
  assign sqrt_shift = {rem, dvd[63:62]};
  assign offset     = prod[35:8];

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:      if (in_acc) state_next = ST_UPD;
      ST_UPD:       state_next = ST_SQ_ADD;
      ST_SQ_ADD:    state_next = ST_SQ_SUB;
      ST_SQ_SUB:    state_next = full_now ? ST_LQ_LO : ST_RES;
      ST_LQ_LO:     state_next = ST_LQ_HI;
      ST_LQ_HI:     state_next = ST_SS;
      ST_SS:        state_next = ST_NUM;
      ST_NUM:       state_next = ST_LL;
      ST_LL:        state_next = ST_DIV_VAR;
      ST_DIV_VAR:   if (cnt == CNT_W'(1)) state_next = ST_MEAN_INIT;
      ST_MEAN_INIT: state_next = ST_DIV_MEAN;
      ST_DIV_MEAN:  if (cnt == CNT_W'(1)) state_next = ST_SQRT_INIT;
      ST_SQRT_INIT: state_next = ST_SQRT;
      ST_SQRT:      if (cnt == CNT_W'(1)) state_next = ST_OFF;
      ST_OFF:       state_next = ST_RES;
      ST_RES:       if (can_load) state_next = ST_IDLE;
      default:      state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready = 1'b0;
    ram_we   = 1'b0;
    ram_addr = write_position - len[WIN_AW-1:0];
    mul_a    = '0;
    mul_b    = '0;
    sub_a    = '0;
    sub_b    = '0;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
      end
      ST_UPD: begin
        ram_we   = 1'b1;
        ram_addr = write_position;
        mul_a    = {{(32-PRICE_BITS){1'b0}}, price};
        mul_b    = {{(32-PRICE_BITS){1'b0}}, price};
      end
      ST_SQ_ADD: begin
        mul_a = {{(32-PRICE_BITS){1'b0}}, old_price};
        mul_b = {{(32-PRICE_BITS){1'b0}}, old_price};
      end
      ST_LQ_LO: begin
        mul_a = {4'b0, window_square_sum[27:0]};
        mul_b = {{(32-LEN_W){1'b0}}, len};
      end
      ST_LQ_HI: begin
        mul_a = {4'b0, window_square_sum[55:28]};
        mul_b = {{(32-LEN_W){1'b0}}, len};
      end
      ST_SS: begin
        mul_a = window_sum;
        mul_b = window_sum;
      end
      ST_NUM: begin
        mul_a = {{(32-LEN_W){1'b0}}, len};
        mul_b = {{(32-LEN_W){1'b0}}, len};
      end
      ST_DIV_VAR, ST_DIV_MEAN: begin
        sub_a = {9'b0, div_shift};
        sub_b = {10'b0, divisor};
      end
      ST_SQRT: begin
        sub_a = sqrt_shift;
        sub_b = {1'b0, root, 2'b01};
      end
      // offset product is held while the result waits
      ST_OFF, ST_RES: begin
        mul_a = {{(32-MULT_W){1'b0}}, band_multiplier};
        mul_b = {8'b0, root};
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      window_length     <= WINDOW_LENGTH_RST;
      band_multiplier   <= BAND_MULTIPLIER_RST;
      fill_count        <= '0;
      window_sum        <= '0;
      window_square_sum <= '0;
      write_position    <= '0;
      out_valid         <= 1'b0;
    end else begin
      if (cfg_we && paddr[2] == REG_WINDOW_LENGTH) begin
        window_length     <= pwdata[LEN_W-1:0];
        fill_count        <= '0;
        window_sum        <= '0;
        window_square_sum <= '0;
      end else if (cfg_we && paddr[2] == REG_BAND_MULTIPLIER) begin
        band_multiplier <= pwdata[MULT_W-1:0];
      end else if (state == ST_UPD) begin
        window_sum     <= window_sum - {{(SUM_W-PRICE_BITS){1'b0}}, (was_full ? ram_rdata : '0)}
                          + {{(SUM_W-PRICE_BITS){1'b0}}, price};
        fill_count     <= was_full ? len : fill_count + LEN_W'(1);
        write_position <= write_position + WIN_AW'(1);
      end else if (state == ST_SQ_ADD) begin
        window_square_sum <= window_square_sum + {8'b0, prod[47:0]};
      end else if (state == ST_SQ_SUB) begin
        window_square_sum <= window_square_sum - {8'b0, prod[47:0]};
      end
      if (state == ST_RES && can_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    prod <= mul_p;
    case (state)
      ST_IDLE: begin
        price    <= sample_price;
        was_full <= full_now;
      end
      ST_UPD: begin
        old_price <= was_full ? ram_rdata : '0;
      end
      ST_SQ_SUB: begin
        band_ok <= full_now;
      end
      ST_LQ_HI: begin
        acc <= prod;
      end
      ST_SS: begin
        acc <= acc + {prod[35:0], 28'd0};
      end
      ST_NUM: begin
        acc <= (acc > prod) ? acc - prod : '0;
      end
      ST_LL: begin
        divisor <= prod[16:0];
        dvd     <= acc;
        rem     <= '0;
        cnt     <= DIV_VAR_STEPS;
      end
      ST_DIV_VAR, ST_DIV_MEAN: begin
        rem <= {8'b0, (sub_ok ? sub_diff[16:0] : div_shift[16:0])};
        dvd <= {dvd[62:0], sub_ok};
        cnt <= cnt - CNT_W'(1);
      end
      ST_MEAN_INIT: begin
        acc     <= dvd;
        dvd     <= {window_sum, 32'd0};
        divisor <= {{(17-LEN_W){1'b0}}, len};
        rem     <= '0;
        cnt     <= DIV_MEAN_STEPS;
      end
      ST_SQRT_INIT: begin
        mean <= dvd[23:0];
        dvd  <= {acc[47:0], 16'd0};
        rem  <= '0;
        root <= '0;
        cnt  <= SQRT_STEPS;
      end
      ST_SQRT: begin
        rem  <= sub_ok ? sub_diff[24:0] : sqrt_shift[24:0];
        root <= {root[22:0], sub_ok};
        dvd  <= {dvd[61:0], 2'b00};
        cnt  <= cnt - CNT_W'(1);
      end
      ST_RES: begin
        if (can_load) begin
          ready_res  <= band_ok;
          upper_band <= band_ok ? ({4'b0, mean} + offset) : '0;
          lower_band <= band_ok ? $signed({5'b0, mean} - {1'b0, offset}) : '0;
        end
      end
      default: begin
        cnt <= cnt;
      end
    endcase
  end

endmodule

@@ rtl/bbc_checker.sv @@
`timescale 1ns / 1ps
`include "bollinger_band_calculator_assert.svh"

module bbc_checker (
  input logic               clk,
  input logic               rst,
  input logic               in_valid,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input logic               ready_res,
  input logic [27:0]        upper_band,
  input logic signed [28:0] lower_band
);

  `BBC_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(ready_res) && $stable(upper_band) && $stable(lower_band))
  `BBC_ASSERT_NEXT(a_busy_after_take, in_valid && in_ready, !in_ready)
  `BBC_ASSERT_NOW(a_zero_when_filling, out_valid && !ready_res, upper_band == 28'd0 && lower_band == 29'sd0)
  `BBC_ASSERT_NOW(a_band_order, out_valid && ready_res, $signed({1'b0, upper_band}) >= lower_band)

endmodule

bind bollinger_band_calculator bbc_checker u_bbc_checker (.*);

@@ test/tb_bollinger_band_calculator.sv @@
`timescale 1ns / 1ps

module tb_bollinger_band_calculator;
  import bbc_pkg::*;

  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int SETTLE_CYCLES = 20;
  localparam int TAIL_CYCLES = 200;
  localparam int HOLD_CYCLES = 600;
  localparam logic [PRICE_BITS-1:0] PRICE_MAX = {PRICE_BITS{1'b1}};
  localparam logic [LEN_W-1:0] LEN_FIELD_MAX = {LEN_W{1'b1}};
  localparam logic [MULT_W-1:0] MULT_MAX = {MULT_W{1'b1}};

  typedef struct packed {
    logic        ready;
    logic [27:0] upper;
    logic [28:0] lower;
  } band_t;

  class band_predictor;
    bit [PRICE_BITS-1:0] prices [MAX_WINDOW];
    bit [63:0]           sum_p;
    bit [63:0]           sum_sq;
    int unsigned         filled;
    bit [WIN_AW-1:0]     wr_pos;
    bit [LEN_W-1:0]      win_len;
    bit [MULT_W-1:0]     mult;
    band_t               expected_bands [$];
    int                  mismatches;

    function new();
      win_len = WINDOW_LENGTH_RST;
      mult = BAND_MULTIPLIER_RST;
    endfunction

    function int pending();
      return expected_bands.size();
    endfunction

    function void set_reg(logic idx, logic [31:0] value);
      if (idx == REG_WINDOW_LENGTH) begin
        win_len = value[LEN_W-1:0];
        filled = 0;
        sum_p = '0;
        sum_sq = '0;
      end else begin
        mult = value[MULT_W-1:0];
      end
    endfunction

    function bit [63:0] isqrt(bit [63:0] v);
      bit [63:0] root;
      bit [63:0] cand;
      root = '0;
      for (int b = 31; b >= 0; b--) begin
        cand = root | (64'd1 << b);
        if (cand * cand <= v) root = cand;
      end
      return root;
    endfunction

    function void note_price(bit [PRICE_BITS-1:0] p);
      int unsigned     len;
      bit [WIN_AW-1:0] old_pos;
      bit [63:0]       old, pw, l, mean, lq, ss, variance, dev, offs;
      band_t           b;
      len = (win_len == 0) ? 1 : (win_len > MAX_WINDOW) ? MAX_WINDOW : win_len;
      if (filled >= len) begin
        old_pos = wr_pos - WIN_AW'(len);
        old = prices[old_pos];
        sum_p -= old;
        sum_sq -= old * old;
        filled = len;
      end else begin
        filled++;
      end
      pw = p;
      prices[wr_pos] = p;
      sum_p += pw;
      sum_sq += pw * pw;
      wr_pos++;
      b = '0;
      if (filled >= len) begin
        l = len;
        mean = sum_p / l;
        lq = l * sum_sq;
        ss = sum_p * sum_p;
        variance = (lq > ss) ? (lq - ss) / (l * l) : 64'd0;
        dev = isqrt(variance);
        offs = (64'(mult) * dev) >> 8;
        b.ready = 1'b1;
        b.upper = 28'(mean + offs);
        b.lower = 29'(mean - offs);
      end
      expected_bands = {expected_bands, b};
    endfunction

    function void check_bands(logic r, logic [27:0] u, logic [28:0] lo);
      band_t e;
      if (expected_bands.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: ready %0b upper %0d lower %0d", r, u, $signed(lo));
        return;
      end
      e = expected_bands.pop_front();
      if (r !== e.ready || u !== e.upper || lo !== e.lower) begin
        mismatches++;
        if (mismatches <= 10)
          $display("band mismatch: exp ready %0b upper %0d lower %0d, got ready %0b upper %0d lower %0d",
                   e.ready, e.upper, $signed(e.lower), r, u, $signed(lo));
      end
    endfunction
  endclass

  logic                  clk;
  logic                  rst;
  logic                  in_valid;
  logic                  in_ready;
  logic [PRICE_BITS-1:0] sample_price;
  logic                  out_valid;
  logic                  out_ready;
  logic                  ready_res;
  logic [27:0]           upper_band;
  logic signed [28:0]    lower_band;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [2:0]            paddr;
  logic [31:0]           pwdata;
  logic [31:0]           prdata;
  logic                  pready;

  band_predictor         model;
  bit                    steady;
  bit                    hold_req;
  bit [PRICE_BITS-1:0]   drift_base;
  int                    cycle_count;

  bollinger_band_calculator u_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .sample_price(sample_price),
    .out_valid(out_valid), .out_ready(out_ready),
    .ready_res(ready_res), .upper_band(upper_band), .lower_band(lower_band),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready)
      model.check_bands(ready_res, upper_band, lower_band);
  end

  // receiver: random stalls, plus one long hold-off on request
  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end else begin
        out_ready <= steady || ($urandom_range(99) >= 34);
      end
    end
  end

  function automatic bit [PRICE_BITS-1:0] next_price();
    int unsigned pick;
    pick = $urandom_range(0, 9);
    case (pick)
      0: return '0;
      1: return PRICE_MAX;
      2, 3: return PRICE_BITS'($urandom());
      4: return PRICE_BITS'($urandom_range(0, 255));
      default: begin
        if ($urandom_range(0, 15) == 0) drift_base = PRICE_BITS'($urandom());
        return drift_base + PRICE_BITS'($urandom_range(0, 4095));
      end
    endcase
  endfunction

  task automatic offer_price(input bit [PRICE_BITS-1:0] p);
    int gap;
    @(negedge clk);
    in_valid <= 1'b1;
    sample_price <= p;
    do @(posedge clk); while (!in_ready);
    model.note_price(p);
    if (!steady && $urandom_range(99) < 34) begin
      gap = ($urandom_range(3) == 0) ? $urandom_range(1, 140) : $urandom_range(1, 4);
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  task automatic end_burst();
    @(negedge clk);
    in_valid <= 1'b0;
  endtask

  task automatic drain(input int extra);
    while (model.pending() != 0) @(posedge clk);
    repeat (extra) @(posedge clk);
  endtask

  task automatic cfg_write(input logic idx, input logic [31:0] value);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    model.set_reg(idx, value);
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic run_prices(input int count, input int hold_at, input int pause_at);
    for (int i = 0; i < count; i++) begin
      if (i == hold_at) hold_req = 1'b1;
      if (i == pause_at) begin
        end_burst();
        drain(0);
      end
      offer_price(next_price());
    end
    end_burst();
    drain(SETTLE_CYCLES);
  endtask

  initial begin
    model = new();
    rst = 1'b1;
    in_valid = 1'b0;
    sample_price = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    steady = 1'b0;
    hold_req = 1'b0;
    drift_base = PRICE_BITS'($urandom());
    repeat (12) @(negedge clk);
    rst <= 1'b0;

    // reset settings: fill with alternating extremes for the widest band
    for (int i = 0; i < 20; i++) offer_price(i[0] ? PRICE_MAX : '0);
    offer_price(PRICE_MAX);
    offer_price(24'h555555);
    end_burst();
    drain(SETTLE_CYCLES);

    // zero length acts as one
    cfg_write(REG_WINDOW_LENGTH, 32'd0);
    cfg_write(REG_BAND_MULTIPLIER, 32'(MULT_MAX));
    offer_price(PRICE_MAX);
    offer_price('0);
    end_burst();
    drain(SETTLE_CYCLES);

    cfg_write(REG_WINDOW_LENGTH, 32'd2);
    offer_price('0);
    offer_price(PRICE_MAX);
    offer_price(PRICE_MAX);
    end_burst();
    drain(SETTLE_CYCLES);

    // multiplier change keeps the window
    cfg_write(REG_BAND_MULTIPLIER, 32'd0);
    steady = 1'b1;
    run_prices(10, -1, -1);

    cfg_write(REG_WINDOW_LENGTH, 32'd1);
    cfg_write(REG_BAND_MULTIPLIER, 32'(MULT_MAX));
    run_prices(30, -1, -1);
    steady = 1'b0;

    for (int k = 0; k < 3; k++) begin
      cfg_write(REG_WINDOW_LENGTH, $urandom_range(3, 40));
      cfg_write(REG_BAND_MULTIPLIER, $urandom_range(0, MULT_MAX));
      run_prices(40, (k == 0) ? 20 : -1, (k == 1) ? 20 : -1);
    end

    // length beyond the ring saturates to a full ring
    cfg_write(REG_WINDOW_LENGTH, 32'(LEN_FIELD_MAX));
    cfg_write(REG_BAND_MULTIPLIER, $urandom_range(0, MULT_MAX));
    run_prices(MAX_WINDOW + 6, -1, -1);

    drain(TAIL_CYCLES);
    if (model.mismatches == 0 && model.pending() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
